// File: design/barometer_sample_compensation_defines.svh
// Assertion macros shared by the barometer compensation design.
`ifndef BAROMETER_SAMPLE_COMPENSATION_DEFINES_SVH
`define BAROMETER_SAMPLE_COMPENSATION_DEFINES_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define BSC_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bsc check failed");

// Next-cycle implication, sampled on clock and disabled during reset.
`define BSC_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bsc check failed");

`endif

// File: design/bsc_pkg.sv
// Types, constants and helper functions of the barometer compensation design.
`timescale 1ns / 1ps
package bsc_pkg;

   typedef logic signed [31:0] s32_type;

   typedef struct packed {
      logic [15:0] raw_temperature;
      logic [23:0] raw_pressure_bytes;
   } req_item_type;

   typedef struct packed {
      logic signed [15:0] temperature_tenths;
      logic [19:0]        pressure_pa;
      logic               divide_error;
   } rsp_item_type;

   typedef struct packed {
      logic [63:0] word_a;
      logic [63:0] word_b;
      logic [31:0] word_c;
      logic [1:0]  oversampling;
   } cal_type;

   // Item handed from the front part to the back part.
   typedef struct packed {
      s32_type     x1;
      logic [23:0] up;
   } mid_item_type;

   // Per-item values that ride alongside the arithmetic.
   typedef struct packed {
      logic               err;
      logic signed [15:0] t;
      logic [23:0]        up;
   } side_type;

   typedef struct packed {
      side_type side;
      logic     neg;
      s32_type  x1;
   } ctx_type;

   typedef enum logic [1:0] {
      CSR_CAL_WORD_A   = 2'd0,
      CSR_CAL_WORD_B   = 2'd1,
      CSR_CAL_WORD_C   = 2'd2,
      CSR_OVERSAMPLING = 2'd3
   } csr_index_type;

   localparam int      DIV_BITS       = 32;
   localparam logic [1:0] OSS_RESET   = 2'd2;
   localparam s32_type C_T_ROUND      = 32'sd8;
   localparam s32_type C_B6_OFFSET    = 32'sd4000;
   localparam s32_type C_B3_ROUND     = 32'sd2;
   localparam s32_type C_B4_OFFSET    = 32'sd32768;
   localparam logic [31:0] C_B7_SCALE = 32'd50000;
   localparam s32_type C_P_SQ         = 32'sd3038;
   localparam s32_type C_P_LIN        = -32'sd7357;
   localparam s32_type C_P_OFFSET     = 32'sd3791;
   localparam s32_type T_MAX          = 32'sd32767;
   localparam s32_type T_MIN          = -32'sd32768;
   localparam s32_type P_MAX          = 32'sd1048575;

   function automatic s32_type sext16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   // Division by 2**k that truncates towards zero.
   function automatic s32_type sdiv_pow2(input s32_type a, input logic [4:0] k);
      s32_type bias;
      bias = a[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
      return (a + bias) >>> k;
   endfunction

endpackage

// File: design/bsc_front.sv
// Front part: takes items, forms the raw pressure and the first temperature term.
`timescale 1ns / 1ps
module bsc_front import bsc_pkg::*; (
   input  logic         req_push,
   input  req_item_type req_item,
   input  logic         mid_full,
   input  cal_type      cal,
   output logic         mid_push,
   output mid_item_type mid_wr_item
);

   s32_type ut;
   s32_type ac5;
   s32_type ac6;
   s32_type diff;
   s32_type prod;

   assign ut   = s32_type'({16'd0, req_item.raw_temperature});
   assign ac5  = s32_type'({16'd0, cal.word_b[63:48]});
   assign ac6  = s32_type'({16'd0, cal.word_b[47:32]});
   assign diff = ut - ac6;
   assign prod = diff * ac5;

   assign mid_push       = req_push && !mid_full;
   assign mid_wr_item.x1 = sdiv_pow2(prod, 5'd15);
   assign mid_wr_item.up = req_item.raw_pressure_bytes >> (4'd8 - {2'b00, cal.oversampling});

endmodule

// File: design/bsc_queue.sv
// Short queue between the front and back parts.
`timescale 1ns / 1ps
module bsc_queue import bsc_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  mid_item_type wr_item,
   input  logic         pop,
   output mid_item_type rd_item,
   output logic         full,
   output logic         empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   mid_item_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

// File: design/bsc_div.sv
// Pipelined unsigned 32-bit divider, one quotient bit per stage.
`timescale 1ns / 1ps
module bsc_div import bsc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [31:0] in_dividend,
   input  logic [31:0] in_divisor,
   input  ctx_type     in_ctx,
   output logic        out_valid,
   output logic [31:0] out_quotient,
   output ctx_type     out_ctx
);

   logic        vld_ff [DIV_BITS];
   logic        vld_in [DIV_BITS];
   logic [31:0] rem_ff [DIV_BITS];
   logic [31:0] rem_in [DIV_BITS];
   logic [31:0] quo_ff [DIV_BITS];
   logic [31:0] quo_in [DIV_BITS];
   logic [31:0] dvs_ff [DIV_BITS];
   logic [31:0] dvs_in [DIV_BITS];
   ctx_type     ctx_ff [DIV_BITS];
   ctx_type     ctx_in [DIV_BITS];

   // The quotient register starts as the dividend; its top bit is shifted
   // into the remainder and the new quotient bit enters at the bottom.
   always_comb begin
      logic [31:0] s_rem;
      logic [31:0] s_quo;
      logic [32:0] trial;
      logic        ge;
      for (int g = 0; g < DIV_BITS; g++) begin
         if (g == 0) begin
            vld_in[g] = in_valid;
            s_rem     = '0;
            s_quo     = in_dividend;
            dvs_in[g] = in_divisor;
            ctx_in[g] = in_ctx;
         end else begin
            vld_in[g] = vld_ff[g-1];
            s_rem     = rem_ff[g-1];
            s_quo     = quo_ff[g-1];
            dvs_in[g] = dvs_ff[g-1];
            ctx_in[g] = ctx_ff[g-1];
         end
         trial     = {s_rem, s_quo[31]};
         ge        = (trial >= {1'b0, dvs_in[g]});
         rem_in[g] = ge ? 32'(trial - {1'b0, dvs_in[g]}) : trial[31:0];
         quo_in[g] = {s_quo[30:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int g = 0; g < DIV_BITS; g++) begin
            vld_ff[g] <= 1'b0;
         end
      end else if (en) begin
         for (int g = 0; g < DIV_BITS; g++) begin
            vld_ff[g] <= vld_in[g];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int g = 0; g < DIV_BITS; g++) begin
            rem_ff[g] <= rem_in[g];
            quo_ff[g] <= quo_in[g];
            dvs_ff[g] <= dvs_in[g];
            ctx_ff[g] <= ctx_in[g];
         end
      end
   end

   assign out_valid    = vld_ff[DIV_BITS-1];
   assign out_quotient = quo_ff[DIV_BITS-1];
   assign out_ctx      = ctx_ff[DIV_BITS-1];

endmodule

// File: design/bsc_back.sv
// Back part: compensation pipeline with two dividers and the result queue.
`timescale 1ns / 1ps
module bsc_back import bsc_pkg::*; #(
   parameter int OUT_DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  cal_type      cal,
   input  mid_item_type mid_item,
   input  logic         mid_empty,
   output logic         mid_pop,
   output rsp_item_type rsp_item,
   output logic         rsp_empty,
   input  logic         rsp_pop
);

   localparam int PTR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
   localparam int CNT_W = $clog2(OUT_DEPTH + 1);

   s32_type     ac1, ac2, ac3, b1, b2, mc, md;
   logic [15:0] ac4;
   logic [1:0]  oss;
   logic        adv;
   logic        out_full;

   assign ac1 = sext16(cal.word_a[63:48]);
   assign ac2 = sext16(cal.word_a[47:32]);
   assign ac3 = sext16(cal.word_a[31:16]);
   assign ac4 = cal.word_a[15:0];
   assign b1  = sext16(cal.word_b[31:16]);
   assign b2  = sext16(cal.word_b[15:0]);
   assign mc  = sext16(cal.word_c[31:16]);
   assign md  = sext16(cal.word_c[15:0]);
   assign oss = cal.oversampling;

   // The whole pipeline moves together unless stage J holds a result and the result queue is full.
   logic j_vld_ff;
   assign adv     = !(j_vld_ff && out_full);
   assign mid_pop = adv && !mid_empty;

   // Stage 0: temperature divisor and magnitudes for the signed division.
   logic        s0_vld_ff, s0_vld_in;
   logic [31:0] s0_dvd_ff, s0_dvd_in;
   logic [31:0] s0_dvs_ff, s0_dvs_in;
   ctx_type     s0_ctx_ff, s0_ctx_in;

   always_comb begin
      s32_type den;
      s32_type num;
      den                = mid_item.x1 + md;
      num                = mc <<< 11;
      s0_vld_in          = !mid_empty;
      s0_dvd_in          = num[31] ? 32'(-num) : 32'(num);
      s0_dvs_in          = den[31] ? 32'(-den) : 32'(den);
      s0_ctx_in.side.err = (den == 32'sd0);
      s0_ctx_in.side.t   = '0;
      s0_ctx_in.side.up  = mid_item.up;
      s0_ctx_in.neg      = num[31] ^ den[31];
      s0_ctx_in.x1       = mid_item.x1;
   end

   logic        d1_vld;
   logic [31:0] d1_quo;
   ctx_type     d1_ctx;

   bsc_div u_div_temp (
      .clock        (clock),
      .reset        (reset),
      .en           (adv),
      .in_valid     (s0_vld_ff),
      .in_dividend  (s0_dvd_ff),
      .in_divisor   (s0_dvs_ff),
      .in_ctx       (s0_ctx_ff),
      .out_valid    (d1_vld),
      .out_quotient (d1_quo),
      .out_ctx      (d1_ctx)
   );

   // Stage A: temperature and B6.
   logic     a_vld_ff;
   s32_type  a_b6_ff, a_b6_in;
   side_type a_side_ff, a_side_in;

   always_comb begin
      s32_type x2;
      s32_type b5;
      s32_type t32;
      x2        = d1_ctx.neg ? -s32_type'(d1_quo) : s32_type'(d1_quo);
      b5        = d1_ctx.x1 + x2;
      t32       = sdiv_pow2(b5 + C_T_ROUND, 5'd4);
      a_b6_in   = b5 - C_B6_OFFSET;
      a_side_in = d1_ctx.side;
      if (t32 > T_MAX) begin
         a_side_in.t = 16'sh7fff;
      end else if (t32 < T_MIN) begin
         a_side_in.t = 16'sh8000;
      end else begin
         a_side_in.t = t32[15:0];
      end
   end

   // Stage B: products of B6.
   logic     b_vld_ff;
   s32_type  b_pbb_ff, b_pbb_in, b_pa2_ff, b_pa2_in, b_pa3_ff, b_pa3_in;
   side_type b_side_ff;

   assign b_pbb_in = a_b6_ff * a_b6_ff;
   assign b_pa2_in = ac2 * a_b6_ff;
   assign b_pa3_in = ac3 * a_b6_ff;

   // Stage C: scaled terms.
   logic     c_vld_ff;
   s32_type  c_sq_ff, c_sq_in, c_x2a_ff, c_x2a_in, c_x1c_ff, c_x1c_in;
   side_type c_side_ff;

   assign c_sq_in  = sdiv_pow2(b_pbb_ff, 5'd12);
   assign c_x2a_in = sdiv_pow2(b_pa2_ff, 5'd11);
   assign c_x1c_in = sdiv_pow2(b_pa3_ff, 5'd13);

   // Stage D: products of the squared term.
   logic     d_vld_ff;
   s32_type  d_pb2_ff, d_pb2_in, d_pb1_ff, d_pb1_in, d_x2a_ff, d_x1c_ff;
   side_type d_side_ff;

   assign d_pb2_in = b2 * c_sq_ff;
   assign d_pb1_in = b1 * c_sq_ff;

   // Stage E: B3 and the X3 that feeds B4.
   logic     e_vld_ff;
   s32_type  e_b3_ff, e_b3_in, e_x3b_ff, e_x3b_in;
   side_type e_side_ff;

   always_comb begin
      s32_type x1;
      s32_type x3;
      s32_type b3p;
      s32_type x2b;
      x1       = sdiv_pow2(d_pb2_ff, 5'd11);
      x3       = x1 + d_x2a_ff;
      b3p      = ((ac1 <<< 2) + x3) <<< oss;
      e_b3_in  = sdiv_pow2(b3p + C_B3_ROUND, 5'd2);
      x2b      = sdiv_pow2(d_pb1_ff, 5'd16);
      e_x3b_in = sdiv_pow2(d_x1c_ff + x2b + C_B3_ROUND, 5'd2);
   end

   // Stage F: B4 and B7.
   logic        f_vld_ff;
   logic [31:0] f_b4_ff, f_b4_in, f_b7_ff, f_b7_in;
   side_type    f_side_ff, f_side_in;

   always_comb begin
      logic [47:0] p48;
      logic [31:0] diff;
      // The offset sum is taken as an unsigned 32-bit word.
      p48       = 48'(ac4) * {16'd0, 32'(e_x3b_ff + C_B4_OFFSET)};
      f_b4_in   = p48[46:15];
      diff      = 32'({8'd0, e_side_ff.up}) - 32'(e_b3_ff);
      f_b7_in   = diff * (C_B7_SCALE >> oss);
      f_side_in = e_side_ff;
      if (p48[46:15] == 32'd0) begin
         f_side_in.err = 1'b1;
      end
   end

   // A B7 with its top bit set is divided first and doubled afterwards.
   ctx_type     d2_in_ctx;
   logic [31:0] d2_in_dvd;
   logic        d2_vld;
   logic [31:0] d2_quo;
   ctx_type     d2_ctx;

   assign d2_in_dvd      = f_b7_ff[31] ? f_b7_ff : {f_b7_ff[30:0], 1'b0};
   assign d2_in_ctx.side = f_side_ff;
   assign d2_in_ctx.neg  = f_b7_ff[31];
   assign d2_in_ctx.x1   = '0;

   bsc_div u_div_pres (
      .clock        (clock),
      .reset        (reset),
      .en           (adv),
      .in_valid     (f_vld_ff),
      .in_dividend  (d2_in_dvd),
      .in_divisor   (f_b4_ff),
      .in_ctx       (d2_in_ctx),
      .out_valid    (d2_vld),
      .out_quotient (d2_quo),
      .out_ctx      (d2_ctx)
   );

   // Stage H: first correction products.
   logic     h_vld_ff;
   s32_type  h_pp_ff, h_pp_in, h_m3_ff, h_m3_in, h_p_ff, h_p_in;
   side_type h_side_ff;

   always_comb begin
      s32_type pa;
      h_p_in  = d2_ctx.neg ? s32_type'({d2_quo[30:0], 1'b0}) : s32_type'(d2_quo);
      pa      = sdiv_pow2(h_p_in, 5'd8);
      h_pp_in = pa * pa;
      h_m3_in = C_P_LIN * h_p_in;
   end

   // Stage I: second correction product.
   logic     i_vld_ff;
   s32_type  i_x1_ff, i_x1_in, i_x2_ff, i_x2_in, i_p_ff;
   side_type i_side_ff;

   assign i_x1_in = h_pp_ff * C_P_SQ;
   assign i_x2_in = sdiv_pow2(h_m3_ff, 5'd16);

   // Stage J: final sum, saturation and error handling.
   s32_type      j_x1_ff, j_x2_ff, j_p_ff;
   side_type     j_side_ff;
   rsp_item_type j_item;

   always_comb begin
      s32_type x1s;
      s32_type pf;
      x1s = sdiv_pow2(j_x1_ff, 5'd16);
      pf  = j_p_ff + sdiv_pow2(x1s + j_x2_ff + C_P_OFFSET, 5'd4);
      j_item.divide_error       = j_side_ff.err;
      j_item.temperature_tenths = j_side_ff.t;
      if (pf[31]) begin
         j_item.pressure_pa = '0;
      end else if (pf > P_MAX) begin
         j_item.pressure_pa = '1;
      end else begin
         j_item.pressure_pa = pf[19:0];
      end
      if (j_side_ff.err) begin
         j_item.temperature_tenths = '0;
         j_item.pressure_pa        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
         a_vld_ff  <= 1'b0;
         b_vld_ff  <= 1'b0;
         c_vld_ff  <= 1'b0;
         d_vld_ff  <= 1'b0;
         e_vld_ff  <= 1'b0;
         f_vld_ff  <= 1'b0;
         h_vld_ff  <= 1'b0;
         i_vld_ff  <= 1'b0;
         j_vld_ff  <= 1'b0;
      end else if (adv) begin
         s0_vld_ff <= s0_vld_in;
         a_vld_ff  <= d1_vld;
         b_vld_ff  <= a_vld_ff;
         c_vld_ff  <= b_vld_ff;
         d_vld_ff  <= c_vld_ff;
         e_vld_ff  <= d_vld_ff;
         f_vld_ff  <= e_vld_ff;
         h_vld_ff  <= d2_vld;
         i_vld_ff  <= h_vld_ff;
         j_vld_ff  <= i_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_dvd_ff <= s0_dvd_in;
         s0_dvs_ff <= s0_dvs_in;
         s0_ctx_ff <= s0_ctx_in;
         a_b6_ff   <= a_b6_in;
         a_side_ff <= a_side_in;
         b_pbb_ff  <= b_pbb_in;
         b_pa2_ff  <= b_pa2_in;
         b_pa3_ff  <= b_pa3_in;
         b_side_ff <= a_side_ff;
         c_sq_ff   <= c_sq_in;
         c_x2a_ff  <= c_x2a_in;
         c_x1c_ff  <= c_x1c_in;
         c_side_ff <= b_side_ff;
         d_pb2_ff  <= d_pb2_in;
         d_pb1_ff  <= d_pb1_in;
         d_x2a_ff  <= c_x2a_ff;
         d_x1c_ff  <= c_x1c_ff;
         d_side_ff <= c_side_ff;
         e_b3_ff   <= e_b3_in;
         e_x3b_ff  <= e_x3b_in;
         e_side_ff <= d_side_ff;
         f_b4_ff   <= f_b4_in;
         f_b7_ff   <= f_b7_in;
         f_side_ff <= f_side_in;
         h_pp_ff   <= h_pp_in;
         h_m3_ff   <= h_m3_in;
         h_p_ff    <= h_p_in;
         h_side_ff <= d2_ctx.side;
         i_x1_ff   <= i_x1_in;
         i_x2_ff   <= i_x2_in;
         i_p_ff    <= h_p_ff;
         i_side_ff <= h_side_ff;
         j_x1_ff   <= i_x1_ff;
         j_x2_ff   <= i_x2_ff;
         j_p_ff    <= i_p_ff;
         j_side_ff <= i_side_ff;
      end
   end

   // Result queue.
   rsp_item_type     out_mem_ff [OUT_DEPTH];
   logic [PTR_W-1:0] out_wr_ff, out_wr_in;
   logic [PTR_W-1:0] out_rd_ff, out_rd_in;
   logic [CNT_W-1:0] out_cnt_ff, out_cnt_in;
   logic             out_push;
   logic             out_pop;

   assign out_full  = (out_cnt_ff == CNT_W'(OUT_DEPTH));
   assign rsp_empty = (out_cnt_ff == '0);
   assign out_push  = j_vld_ff && !out_full;
   assign out_pop   = rsp_pop && !rsp_empty;
   assign rsp_item  = out_mem_ff[out_rd_ff];

   always_comb begin
      out_wr_in  = out_wr_ff;
      out_rd_in  = out_rd_ff;
      out_cnt_in = out_cnt_ff;
      if (out_push) begin
         out_wr_in = (out_wr_ff == PTR_W'(OUT_DEPTH - 1)) ? '0 : out_wr_ff + 1'b1;
      end
      if (out_pop) begin
         out_rd_in = (out_rd_ff == PTR_W'(OUT_DEPTH - 1)) ? '0 : out_rd_ff + 1'b1;
      end
      if (out_push && !out_pop) begin
         out_cnt_in = out_cnt_ff + 1'b1;
      end else if (out_pop && !out_push) begin
         out_cnt_in = out_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff  <= '0;
         out_rd_ff  <= '0;
         out_cnt_ff <= '0;
      end else begin
         out_wr_ff  <= out_wr_in;
         out_rd_ff  <= out_rd_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_mem_ff[out_wr_ff] <= j_item;
      end
   end

endmodule

// File: design/barometer_sample_compensation.sv
// Barometer sample compensation: top level with calibration registers.
//
// Each item carries a raw temperature word and a raw 24-bit pressure reading
// and yields one result: temperature in tenths of a degree, pressure in
// pascals and a flag for a zero divisor. One item is taken per clock cycle
// and results leave at the same rate while the consumer keeps popping. The
// latency from push to a visible result is set mostly by the two 32-stage
// divider pipelines (one quotient bit a stage) for the temperature term and
// for the pressure quotient. The user writes calibration registers through
// the csr port only while no item is in flight; nothing here enforces it.
`timescale 1ns / 1ps
`include "barometer_sample_compensation_defines.svh"
module barometer_sample_compensation import bsc_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   input  req_item_type req_item,
   output logic         req_full,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output rsp_item_type rsp_item,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [63:0]  csr_data
);

   cal_type      cal_ff, cal_in;
   logic         mid_push;
   logic         mid_pop;
   logic         mid_full;
   logic         mid_empty;
   mid_item_type mid_wr_item;
   mid_item_type mid_rd_item;

   assign csr_ready = 1'b1;

   always_comb begin
      cal_in = cal_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CAL_WORD_A:   cal_in.word_a       = csr_data;
            CSR_CAL_WORD_B:   cal_in.word_b       = csr_data;
            CSR_CAL_WORD_C:   cal_in.word_c       = csr_data[31:0];
            CSR_OVERSAMPLING: cal_in.oversampling = csr_data[1:0];
            default:          cal_in = cal_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff.word_a       <= '0;
         cal_ff.word_b       <= '0;
         cal_ff.word_c       <= '0;
         cal_ff.oversampling <= OSS_RESET;
      end else begin
         cal_ff <= cal_in;
      end
   end

   assign req_full = mid_full;

   bsc_front u_front (
      .req_push    (req_push),
      .req_item    (req_item),
      .mid_full    (mid_full),
      .cal         (cal_ff),
      .mid_push    (mid_push),
      .mid_wr_item (mid_wr_item)
   );

   bsc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (mid_push),
      .wr_item (mid_wr_item),
      .pop     (mid_pop),
      .rd_item (mid_rd_item),
      .full    (mid_full),
      .empty   (mid_empty)
   );

   bsc_back #(.OUT_DEPTH(QUEUE_DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cal       (cal_ff),
      .mid_item  (mid_rd_item),
      .mid_empty (mid_empty),
      .mid_pop   (mid_pop),
      .rsp_item  (rsp_item),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

   // A flagged result carries zero temperature and pressure.
   `BSC_ASSERT_IMP(a_err_zero, !rsp_empty && rsp_item.divide_error, rsp_item.temperature_tenths == 16'sd0 && rsp_item.pressure_pa == 20'd0)
   // Only a pop can drain a waiting result.
   `BSC_ASSERT_NXT(a_rsp_keep, !rsp_empty && !rsp_pop, !rsp_empty)
   // An oversampling write lands in the register on the next cycle.
   `BSC_ASSERT_NXT(a_oss_write, csr_valid && csr_index == CSR_OVERSAMPLING, cal_ff.oversampling == $past(csr_data[1:0]))

endmodule
